// ----- hw/rtl/slm3_pkg.sv -----
package slm3_pkg;

  // fixed field widths of the stream
  localparam int unsigned ColorW  = 8;
  localparam int unsigned SatW    = 2 * ColorW;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;

  // geometry defaults
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned DimReset  = 1024;

  // queue depths
  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // what the front decided about one transaction
  typedef struct packed {
    logic emit;
    logic fin;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } pix_flags_t;

endpackage

// ----- hw/rtl/slm3_fifo.sv -----
module slm3_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             data_i,
  input  logic                         pop_i,
  output logic [Width-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/slm3_front.sv -----
module slm3_front #(
  parameter int unsigned MAX_WIDTH  = slm3_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = slm3_pkg::MaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  slm3_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [slm3_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            accept_i,
  input  logic                            cmd_i,
  input  logic [slm3_pkg::ColorW-1:0]     red_i,
  input  logic [slm3_pkg::ColorW-1:0]     green_i,
  input  logic [slm3_pkg::ColorW-1:0]     blue_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    addr_o,
  output logic [slm3_pkg::SatW-1:0]       sat_o,
  output logic [slm3_pkg::CoordW-1:0]     col_o,
  output logic [slm3_pkg::CoordW-1:0]     row_o,
  output slm3_pkg::pix_flags_t            flags_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned DWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned DHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WReset =
    (MAX_WIDTH < slm3_pkg::DimReset) ? MAX_WIDTH : slm3_pkg::DimReset;
  localparam int unsigned HReset =
    (MAX_HEIGHT < slm3_pkg::DimReset) ? MAX_HEIGHT : slm3_pkg::DimReset;

  logic [DWW-1:0] width_q, width_d;
  logic [DHW-1:0] height_q, height_d;
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;

  logic [DWW-1:0] cfg_w;
  logic [DHW-1:0] cfg_h;
  logic [CW:0]    col_inc;
  logic           col_wrap;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_ext, h_m1;
  logic [CW-1:0]  cc;
  logic [RW-1:0]  cr;
  logic           row_ok;

  function automatic logic [slm3_pkg::SatW-1:0] make_sat(
    input logic [slm3_pkg::ColorW-1:0] r,
    input logic [slm3_pkg::ColorW-1:0] g,
    input logic [slm3_pkg::ColorW-1:0] b
  );
    logic [slm3_pkg::ColorW-1:0] hi;
    logic [slm3_pkg::ColorW-1:0] lo;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    // black is kept as fraction 0/1
    if (hi == '0) begin
      return slm3_pkg::SatW'(1);
    end
    return {hi - lo, hi};
  endfunction

  // zero acts as one, above the bound saturates
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_w = DWW'(1);
      cfg_h = DHW'(1);
    end else begin
      cfg_w = (32'(cfg_data_i) > MAX_WIDTH) ? DWW'(MAX_WIDTH) : DWW'(cfg_data_i);
      cfg_h = (32'(cfg_data_i) > MAX_HEIGHT) ? DHW'(MAX_HEIGHT) : DHW'(cfg_data_i);
    end
  end

  assign col_inc  = (CW + 1)'(in_col_q) + (CW + 1)'(1);
  assign col_wrap = (col_inc >= (CW + 1)'(width_q));
  assign w_m1     = CW'(width_q - 1'b1);
  assign h_ext    = RW'(height_q);
  assign h_m1     = h_ext - 1'b1;

  // the transaction decides the pixel one row and one column behind it
  always_comb begin
    if (in_col_q != '0) begin
      cc     = in_col_q - 1'b1;
      cr     = in_row_q - 1'b1;
      row_ok = (in_row_q >= RW'(1));
    end else begin
      cc     = w_m1;
      cr     = in_row_q - RW'(2);
      row_ok = (in_row_q >= RW'(2));
    end
  end

  always_comb begin
    flags_o.emit     = row_ok && (cr < h_ext);
    flags_o.fin      = flags_o.emit && (cr == h_m1) && (cc == w_m1);
    flags_o.top_ok   = (cr != '0);
    flags_o.bot_ok   = (cr != h_m1);
    flags_o.left_ok  = (cc != '0);
    flags_o.right_ok = (cc != w_m1);
  end

  assign addr_o = in_col_q;
  assign col_o  = slm3_pkg::CoordW'(32'(cc));
  assign row_o  = slm3_pkg::CoordW'(32'(cr));
  // pads and pixels of the flush rows count as saturation zero
  assign sat_o  = (!cmd_i && (in_row_q < h_ext)) ? make_sat(red_i, green_i, blue_i)
                                                 : slm3_pkg::SatW'(1);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slm3_pkg::RegFrameWidth:  width_d  = cfg_w;
        slm3_pkg::RegFrameHeight: height_d = cfg_h;
      endcase
      in_col_d = '0;
      in_row_d = '0;
    end else if (accept_i) begin
      if (flags_o.fin) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DWW'(WReset);
      height_q <= DHW'(HReset);
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

endmodule

// ----- hw/rtl/slm3_back.sv -----
module slm3_back #(
  parameter int unsigned MAX_WIDTH = slm3_pkg::MaxWidth
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     clear_i,
  input  logic                                     q_empty_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]             q_addr_i,
  input  logic [slm3_pkg::SatW-1:0]                q_sat_i,
  input  logic [slm3_pkg::CoordW-1:0]              q_col_i,
  input  logic [slm3_pkg::CoordW-1:0]              q_row_i,
  input  slm3_pkg::pix_flags_t                     q_flags_i,
  output logic                                     q_pop_o,
  input  logic [$clog2(slm3_pkg::OutDepth+1)-1:0]  out_count_i,
  output logic                                     out_push_o,
  output logic                                     out_is_max_o,
  output logic [slm3_pkg::CoordW-1:0]              out_col_o,
  output logic [slm3_pkg::CoordW-1:0]              out_row_o,
  output logic                                     out_last_o
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned SatW = slm3_pkg::SatW;
  localparam int unsigned ColW = slm3_pkg::ColorW;
  localparam int unsigned CntW = $clog2(slm3_pkg::OutDepth + 1);

  // line store: upper line in the high half, middle line in the low half
  logic [2*SatW-1:0] line_mem [MAX_WIDTH];
  logic [2*SatW-1:0] line_rd_q;
  logic [2*SatW-1:0] fwd_data_q;
  logic              fwd_hit_q;

  logic                        b_valid_q;
  logic [AW-1:0]               b_addr_q;
  logic [SatW-1:0]             b_sat_q;
  logic [slm3_pkg::CoordW-1:0] b_col_q, b_row_q;
  slm3_pkg::pix_flags_t        b_flags_q;

  logic                        c_valid_q;
  logic [slm3_pkg::CoordW-1:0] c_col_q, c_row_q;
  slm3_pkg::pix_flags_t        c_flags_q;
  logic [SatW-1:0]             win_q [3][3];

  logic                        d_valid_q;
  logic [slm3_pkg::CoordW-1:0] d_col_q, d_row_q;
  logic                        d_emit_q, d_fin_q;
  logic [SatW-1:0]             d_pa_q [3][3];
  logic [SatW-1:0]             d_pb_q [3][3];
  logic [8:0]                  d_allow_q;

  logic [SatW-1:0]   top_sat, mid_sat;
  logic [SatW-1:0]   pa_c [3][3];
  logic [SatW-1:0]   pb_c [3][3];
  logic [8:0]        allow_c;
  logic [1:0]        inflight;
  logic [CntW:0]     reserved;

  // every transaction in flight holds a slot of the result queue
  assign inflight = 2'(b_valid_q) + 2'(c_valid_q) + 2'(d_valid_q);
  assign reserved = (CntW + 1)'(out_count_i) + (CntW + 1)'(inflight);
  assign q_pop_o  = !q_empty_i && (reserved < (CntW + 1)'(slm3_pkg::OutDepth));

  // a read that meets the write of the same entry takes the new data
  assign {top_sat, mid_sat} = fwd_hit_q ? fwd_data_q : line_rd_q;

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      line_mem[b_addr_q] <= {mid_sat, b_sat_q};
    end
    if (q_pop_o) begin
      line_rd_q <= line_mem[q_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      b_valid_q <= q_pop_o;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      fwd_hit_q <= q_pop_o && b_valid_q && (b_addr_q == q_addr_i);
      if (clear_i) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_q[i][j] <= '0;
          end
        end
      end else if (b_valid_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= top_sat;
        win_q[1][2] <= mid_sat;
        win_q[2][2] <= b_sat_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= {mid_sat, b_sat_q};
    b_addr_q   <= q_addr_i;
    b_sat_q    <= q_sat_i;
    b_col_q    <= q_col_i;
    b_row_q    <= q_row_i;
    b_flags_q  <= q_flags_i;
    c_col_q    <= b_col_q;
    c_row_q    <= b_row_q;
    c_flags_q  <= b_flags_q;
    d_col_q    <= c_col_q;
    d_row_q    <= c_row_q;
    d_emit_q   <= c_flags_q.emit;
    d_fin_q    <= c_flags_q.fin;
    d_allow_q  <= allow_c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d_pa_q[i][j] <= pa_c[i][j];
        d_pb_q[i][j] <= pb_c[i][j];
      end
    end
  end

  // cross products: center diff * neighbor max against neighbor diff * center max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_c[i][j] = SatW'(win_q[1][1][SatW-1:ColW]) * SatW'(win_q[i][j][ColW-1:0]);
        pb_c[i][j] = SatW'(win_q[i][j][SatW-1:ColW]) * SatW'(win_q[1][1][ColW-1:0]);
        allow_c[i*3+j] = !((i == 1) && (j == 1))
                      && !((i == 0) && !c_flags_q.top_ok)
                      && !((i == 2) && !c_flags_q.bot_ok)
                      && !((j == 0) && !c_flags_q.left_ok)
                      && !((j == 2) && !c_flags_q.right_ok);
      end
    end
  end

  always_comb begin
    out_is_max_o = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (d_allow_q[i*3+j] && !(d_pa_q[i][j] > d_pb_q[i][j])) begin
          out_is_max_o = 1'b0;
        end
      end
    end
  end

  assign out_push_o = d_valid_q && d_emit_q;
  assign out_col_o  = d_col_q;
  assign out_row_o  = d_row_q;
  assign out_last_o = d_fin_q;

endmodule

// ----- hw/rtl/saturation_local_max_3x3.sv -----
// 3x3 local maximum of colour saturation over a raster stream of rgb pixels.
// input queue: drive push with cmd/red/green/blue; a transaction is taken when
// push is high and full is low. cmd set marks a pad; after each frame send
// frame_width+1 pads so the last row is decided.
// result queue: while empty is low the oldest result (is_max, col, row, last)
// is on the ports; pop while empty is low takes it. a transaction decides
// the pixel one row and one column behind it, so the first row produces
// no results and last marks the final pixel of the frame.
// configuration: cfg_we_i writes frame_width (index 0) or frame_height
// (index 1) and restarts the frame; write only while the block is idle.
// throughput is one transaction per cycle while full stays low. a taken
// transaction enters the front queue; then the line store read, the window
// shift, the cross products and the compare into the result queue take one
// register stage each.
// when pop is held low the 8-entry result queue fills, the back end stops
// taking from the front queue and full rises once that 4-entry queue is full.
// reset clears the counters, the window and both queues and restores both
// dimensions to 1024 (clipped to the maximum); the line store needs no clear.
module saturation_local_max_3x3 #(
  parameter int unsigned MAX_WIDTH  = slm3_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = slm3_pkg::MaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  slm3_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [slm3_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd_i,
  input  logic [slm3_pkg::ColorW-1:0]  red_i,
  input  logic [slm3_pkg::ColorW-1:0]  green_i,
  input  logic [slm3_pkg::ColorW-1:0]  blue_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         is_max_o,
  output logic [slm3_pkg::CoordW-1:0]  col_o,
  output logic [slm3_pkg::CoordW-1:0]  row_o,
  output logic                         last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned SatW  = slm3_pkg::SatW;
  localparam int unsigned CrdW  = slm3_pkg::CoordW;
  localparam int unsigned FlagW = $bits(slm3_pkg::pix_flags_t);
  localparam int unsigned MidW  = CW + SatW + 2 * CrdW + FlagW;
  localparam int unsigned OutW  = 2 * CrdW + 2;

  logic                 accept;
  logic [CW-1:0]        f_addr;
  logic [SatW-1:0]      f_sat;
  logic [CrdW-1:0]      f_col, f_row;
  slm3_pkg::pix_flags_t f_flags;

  logic [MidW-1:0]      mid_wdata, mid_rdata;
  logic                 mid_empty, mid_pop;
  logic [$clog2(slm3_pkg::MidDepth+1)-1:0] mid_count;

  logic                 out_push, out_is_max, out_last;
  logic [CrdW-1:0]      out_col, out_row;
  logic [OutW-1:0]      out_wdata, out_rdata;
  logic                 out_full;
  logic [$clog2(slm3_pkg::OutDepth+1)-1:0] out_count;

  assign accept = push && !full;

  slm3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .addr_o     (f_addr),
    .sat_o      (f_sat),
    .col_o      (f_col),
    .row_o      (f_row),
    .flags_o    (f_flags)
  );

  assign mid_wdata = {f_addr, f_sat, f_col, f_row, f_flags};

  slm3_fifo #(
    .Width (MidW),
    .Depth (slm3_pkg::MidDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (mid_wdata),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .full_o  (full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  slm3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_we_i),
    .q_empty_i    (mid_empty || (mid_count == '0)),
    .q_addr_i     (mid_rdata[MidW-1 -: CW]),
    .q_sat_i      (mid_rdata[MidW-CW-1 -: SatW]),
    .q_col_i      (mid_rdata[FlagW+2*CrdW-1 -: CrdW]),
    .q_row_i      (mid_rdata[FlagW+CrdW-1 -: CrdW]),
    .q_flags_i    (slm3_pkg::pix_flags_t'(mid_rdata[FlagW-1:0])),
    .q_pop_o      (mid_pop),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_is_max_o (out_is_max),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .out_last_o   (out_last)
  );

  assign out_wdata = {out_is_max, out_col, out_row, out_last};

  // slots are reserved before a transaction leaves the front queue,
  // so a push never meets a full result queue
  slm3_fifo #(
    .Width (OutW),
    .Depth (slm3_pkg::OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push && !out_full),
    .data_i  (out_wdata),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign is_max_o = out_rdata[OutW-1];
  assign col_o    = out_rdata[OutW-2 -: CrdW];
  assign row_o    = out_rdata[CrdW:1];
  assign last_o   = out_rdata[0];

endmodule

// ----- tb/sv/tb_saturation_local_max_3x3.sv -----
`timescale 1ns / 1ps

module tb_saturation_local_max_3x3;

  localparam int unsigned ColorW    = slm3_pkg::ColorW;
  localparam int unsigned CoordW    = slm3_pkg::CoordW;
  localparam int unsigned CfgW      = slm3_pkg::CfgW;
  localparam int unsigned SatW      = slm3_pkg::SatW;
  localparam int unsigned DimReset  = slm3_pkg::DimReset;
  localparam int unsigned MaxWidth  = slm3_pkg::MaxWidth;
  localparam int unsigned MaxHeight = slm3_pkg::MaxHeight;

  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandItems = 1130;

  typedef struct packed {
    logic              cmd;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic              is_max;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
  } nms_res_t;

  typedef struct {
    nms_res_t res;
    time      stamp;
  } due_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  slm3_pkg::cfg_reg_e cfg_idx_i = slm3_pkg::RegFrameWidth;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic               cmd_i = 1'b0;
  logic [ColorW-1:0]  red_i = '0;
  logic [ColorW-1:0]  green_i = '0;
  logic [ColorW-1:0]  blue_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               is_max_o;
  logic [CoordW-1:0]  col_o;
  logic [CoordW-1:0]  row_o;
  logic               last_o;

  saturation_local_max_3x3 u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .cmd_i     (cmd_i),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .empty     (empty),
    .pop       (pop),
    .is_max_o  (is_max_o),
    .col_o     (col_o),
    .row_o     (row_o),
    .last_o    (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow of the block: geometry, line stores, window, input position
  logic [CfgW-1:0] geom_w = CfgW'(DimReset);
  logic [CfgW-1:0] geom_h = CfgW'(DimReset);
  bit [SatW-1:0]   sat_upper [MaxWidth];
  bit [SatW-1:0]   sat_middle [MaxWidth];
  bit [SatW-1:0]   sat_win [3][3];
  int unsigned     pos_col = 0;
  int unsigned     pos_row = 0;

  pix_t        pixels_todo[$];
  due_t        decisions_due[$];
  int unsigned items_sent = 0;
  int unsigned n_bad = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_tok = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  function automatic int unsigned dim_clip(logic [CfgW-1:0] v, int unsigned bound);
    if (v == '0) return 1;
    if (32'(v) > bound) return bound;
    return 32'(v);
  endfunction

  // saturation as a fraction {max-min, max}; black is 0/1
  function automatic logic [SatW-1:0] sat_of(logic [ColorW-1:0] r, logic [ColorW-1:0] g,
                                             logic [ColorW-1:0] b);
    logic [ColorW-1:0] hi, lo;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    if (hi == '0) return SatW'(1);
    return {hi - lo, hi};
  endfunction

  function automatic bit sat_gt(logic [SatW-1:0] a, logic [SatW-1:0] b);
    int unsigned ad, am, bd, bm;
    ad = 32'(a[SatW-1:ColorW]);
    am = 32'(a[ColorW-1:0]);
    bd = 32'(b[SatW-1:ColorW]);
    bm = 32'(b[ColorW-1:0]);
    return ad * bm > bd * am;
  endfunction

  // advance the shadow by one transaction; returns 1 when a pixel is decided
  function automatic bit nms_decide(pix_t px, output nms_res_t res);
    int unsigned w, h, c;
    int cr, cc, i, j;
    logic [SatW-1:0] v, top, mid;
    bit mx, decided;
    w = dim_clip(geom_w, MaxWidth);
    h = dim_clip(geom_h, MaxHeight);
    c = (pos_col < w) ? pos_col : w - 1;
    v = SatW'(1);
    res = '0;
    mx = 1'b1;
    decided = 1'b0;
    if (!px.cmd && pos_row < h) v = sat_of(px.red, px.green, px.blue);
    top = sat_upper[c];
    mid = sat_middle[c];
    sat_upper[c] = mid;
    sat_middle[c] = v;
    for (i = 0; i < 3; i++) begin
      sat_win[i][0] = sat_win[i][1];
      sat_win[i][1] = sat_win[i][2];
    end
    sat_win[0][2] = top;
    sat_win[1][2] = mid;
    sat_win[2][2] = v;
    if (pos_col >= 1) begin
      cr = int'(pos_row) - 1;
      cc = int'(pos_col) - 1;
    end else begin
      cr = int'(pos_row) - 2;
      cc = int'(w) - 1;
    end
    if (cr >= 0 && cr < int'(h) && cc >= 0 && cc < int'(w)) begin
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          // neighbors outside the frame do not take part
          if (i == 1 && j == 1) continue;
          if (i == 0 && cr == 0) continue;
          if (i == 2 && cr == int'(h) - 1) continue;
          if (j == 0 && cc == 0) continue;
          if (j == 2 && cc == int'(w) - 1) continue;
          if (!sat_gt(sat_win[1][1], sat_win[i][j])) mx = 1'b0;
        end
      end
      res.is_max = mx;
      res.col = cc[CoordW-1:0];
      res.row = cr[CoordW-1:0];
      res.last = (cr == int'(h) - 1) && (cc == int'(w) - 1);
      decided = 1'b1;
      if (res.last) begin
        pos_col = 0;
        pos_row = 0;
        return decided;
      end
    end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
    return decided;
  endfunction

  task automatic cmp_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      n_bad++;
    end
  endtask

  // driver: offers the oldest pending pixel, predicts on each accepted transaction
  always @(posedge clk_i) begin : drv
    nms_res_t r;
    due_t     nd;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (nms_decide(pixels_todo[0], r)) begin
          nd.res = r;
          nd.stamp = $time;
          decisions_due.insert(decisions_due.size(), nd);
        end
        void'(pixels_todo.pop_front());
      end
      if (!push || !full) begin
        if (pixels_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          cmd_i   <= pixels_todo[0].cmd;
          red_i   <= pixels_todo[0].red;
          green_i <= pixels_todo[0].green;
          blue_i  <= pixels_todo[0].blue;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each popped result against the oldest decision due
  always @(posedge clk_i) begin : mon
    due_t d;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        // a decision queued in this same step cannot be the one on the ports
        if (decisions_due.size() == 0 || decisions_due[0].stamp >= $time) begin
          $display("%0t: unexpected result, expected none actual col %0d row %0d",
                   $time, col_o, row_o);
          n_bad++;
        end else begin
          d = decisions_due.pop_front();
          cmp_field("is_max", 32'(d.res.is_max), 32'(is_max_o));
          cmp_field("col", 32'(d.res.col), 32'(col_o));
          cmp_field("row", 32'(d.res.row), 32'(row_o));
          cmp_field("last", 32'(d.res.last), 32'(last_o));
        end
      end
      if (hold_tok != hold_ack) begin
        hold_ack = hold_tok;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StuckLimit);
      $display("[saturation_local_max_3x3] ERROR");
      $finish;
    end
  end

  function automatic void queue_px(pix_t p);
    pixels_todo.insert(pixels_todo.size(), p);
    items_sent++;
  endfunction

  function automatic logic [ColorW-1:0] pal_level();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // 0: uniform colors, 1: few levels so equal fractions are common,
  // 2: mostly gray with scattered saturated peaks
  function automatic pix_t rand_px(int unsigned style);
    pix_t p;
    logic [ColorW-1:0] lvl;
    p.cmd = 1'b0;
    case (style)
      0: begin
        p.red   = ColorW'($urandom_range(255));
        p.green = ColorW'($urandom_range(255));
        p.blue  = ColorW'($urandom_range(255));
      end
      1: begin
        p.red   = pal_level();
        p.green = pal_level();
        p.blue  = pal_level();
      end
      default: begin
        lvl = ColorW'($urandom_range(255));
        p.red   = lvl;
        p.green = lvl;
        p.blue  = lvl;
        if ($urandom_range(5) == 0) p.blue = ColorW'($urandom_range(255));
      end
    endcase
    return p;
  endfunction

  task automatic write_geom(slm3_pkg::cfg_reg_e idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == slm3_pkg::RegFrameWidth) geom_w = val;
    else geom_h = val;
    pos_col = 0;
    pos_row = 0;
    sat_win = '{default: '0};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one frame plus its flush; now and then the flush is cut short or overlong
  task automatic send_frame(int unsigned w, int unsigned h);
    int unsigned style, n_flush, k;
    pix_t p;
    style = $urandom_range(2);
    n_flush = w + 1;
    if ($urandom_range(9) == 0) n_flush = $urandom_range(w + 3);
    @(negedge clk_i);
    for (k = 0; k < w * h; k++) begin
      p = rand_px(style);
      if ($urandom_range(24) == 0) p.cmd = 1'b1;
      queue_px(p);
    end
    for (k = 0; k < n_flush; k++) begin
      p = rand_px(0);
      p.cmd = ($urandom_range(7) != 0);
      queue_px(p);
    end
  endtask

  task automatic send_cur_frame();
    send_frame(dim_clip(geom_w, MaxWidth), dim_clip(geom_h, MaxHeight));
  endtask

  // wait until every decision has come out and the pipeline is quiet
  task automatic settle();
    do @(negedge clk_i);
    while (pixels_todo.size() != 0 || push || decisions_due.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_idle(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 74; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 74; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  function automatic logic [CfgW-1:0] pick_dim(int unsigned top);
    case ($urandom_range(9))
      0: return '0;
      1: return CfgW'($urandom_range(top + 1, 3 * top));
      default: return CfgW'($urandom_range(1, top));
    endcase
  endfunction

  initial begin : stim
    int unsigned ph, nfr, f, base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: color extremes, equal fractions, black, pads inside the frame
    // and a pixel during the flush
    set_idle(0);
    write_geom(slm3_pkg::RegFrameWidth, 11'd4);
    write_geom(slm3_pkg::RegFrameHeight, 11'd3);
    @(negedge clk_i);
    queue_px('{1'b0, 8'd0, 8'd0, 8'd0});
    queue_px('{1'b0, 8'd255, 8'd255, 8'd255});
    queue_px('{1'b0, 8'd255, 8'd0, 8'd0});
    queue_px('{1'b0, 8'd128, 8'd0, 8'd0});
    queue_px('{1'b0, 8'd10, 8'd200, 8'd30});
    queue_px('{1'b1, 8'd255, 8'd255, 8'd0});
    queue_px('{1'b0, 8'd255, 8'd128, 8'd0});
    queue_px('{1'b0, 8'd127, 8'd127, 8'd1});
    queue_px('{1'b0, 8'd1, 8'd1, 8'd0});
    queue_px('{1'b0, 8'd200, 8'd100, 8'd50});
    queue_px('{1'b0, 8'd0, 8'd0, 8'd255});
    queue_px('{1'b0, 8'd254, 8'd1, 8'd128});
    queue_px('{1'b1, 8'd0, 8'd0, 8'd0});
    queue_px('{1'b0, 8'd255, 8'd0, 8'd255});
    queue_px('{1'b1, 8'd0, 8'd0, 8'd0});
    queue_px('{1'b1, 8'd0, 8'd0, 8'd0});
    queue_px('{1'b1, 8'd0, 8'd0, 8'd0});
    settle();

    // zero geometry acts as a single pixel frame
    write_geom(slm3_pkg::RegFrameWidth, 11'd0);
    write_geom(slm3_pkg::RegFrameHeight, 11'd0);
    send_cur_frame();
    settle();

    // random frames over small geometries, cycling through idle patterns
    ph = 0;
    base = items_sent;
    while (items_sent - base < RandItems) begin
      set_idle(ph % 4);
      if (ph == 0) begin
        write_geom(slm3_pkg::RegFrameWidth, 11'd6);
        write_geom(slm3_pkg::RegFrameHeight, 11'd5);
      end else if (ph < 4 || $urandom_range(2) == 0) begin
        write_geom(slm3_pkg::RegFrameWidth, pick_dim(10));
        write_geom(slm3_pkg::RegFrameHeight, pick_dim(8));
      end else if ($urandom_range(1) == 0) begin
        write_geom(slm3_pkg::RegFrameWidth, pick_dim(10));
      end else begin
        write_geom(slm3_pkg::RegFrameHeight, pick_dim(8));
      end
      nfr = (ph < 2) ? 2 : $urandom_range(1, 3);
      // receiver holds off while the sender keeps pushing
      if (ph == 0) hold_tok++;
      for (f = 0; f < nfr; f++) begin
        send_cur_frame();
        // sender stops mid-stream until everything has drained
        if (ph == 1 && f == 0) settle();
      end
      settle();
      ph++;
    end

    if (n_bad == 0) begin
      $display("[saturation_local_max_3x3] OK");
    end else begin
      $display("[saturation_local_max_3x3] ERROR");
    end
    $finish;
  end

endmodule
